@@ hw/rtl/framed_link_receiver_with_watchdog_defines.svh @@
// Assertion macros shared by the framed link receiver checkers.
`ifndef FRAMED_LINK_RECEIVER_WITH_WATCHDOG_DEFINES_SVH
`define FRAMED_LINK_RECEIVER_WITH_WATCHDOG_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define FLRW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define FLRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/flrw_pkg.sv @@
// Package with the shared types and constants of the framed link receiver.
package flrw_pkg;

    localparam int PAYLOAD_BYTES_DEF = 28;
    localparam int APB_AW = 5;
    localparam logic [19:0] SILENCE_MAX = 20'hFFFFF;

    localparam logic [2:0] REG_START_BYTE   = 3'd0;
    localparam logic [2:0] REG_RESET_BYTE   = 3'd1;
    localparam logic [2:0] REG_ACK_REPLY    = 3'd2;
    localparam logic [2:0] REG_NACK_REPLY   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT      = 3'd4;

    localparam logic [7:0]  START_BYTE_RST = 8'd2;
    localparam logic [7:0]  RESET_BYTE_RST = 8'd187;
    localparam logic [7:0]  ACK_REPLY_RST  = 8'd6;
    localparam logic [7:0]  NACK_REPLY_RST = 8'd21;
    localparam logic [19:0] TIMEOUT_RST    = 20'd500;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_NACK    = 2'd1;
    localparam logic [1:0] EV_RESET   = 2'd2;
    localparam logic [1:0] EV_STOP    = 2'd3;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_LEN   = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } flrw_in_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       last;
        logic       reply_valid;
        logic [7:0] reply_byte;
    } flrw_out_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  reset_frame_byte;
        logic [7:0]  ack_reply;
        logic [7:0]  nack_reply;
        logic [19:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic burst_load;
        logic burst_inc;
    } cmd_t;

    typedef struct packed {
        logic burst_start;
        logic burst_last;
        logic slot_free;
    } sts_t;

endpackage

@@ hw/rtl/flrw_dp.sv @@
// Datapath: frame parser, frame store, silence watchdog and output register.
module flrw_dp
    import flrw_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    output sts_t      sts,
    input  flrw_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output flrw_out_t out_data
);

    localparam int AW = $clog2(PAYLOAD_BYTES);
    localparam logic [5:0] P6 = 6'(PAYLOAD_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_BYTES - 1);

    phase_t          phase_reg, phase_next;
    logic            kind_reg, kind_next;
    logic [5:0]      fill_reg, fill_next;
    logic [19:0]     silence_reg, silence_next;
    logic            stop_reg, stop_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      rd_data_reg;
    logic            out_valid_reg, out_valid_next;
    flrw_out_t       out_data_reg, out_data_next;
    logic [7:0]      mem [PAYLOAD_BYTES];

    logic            wr_en;
    logic            single_load;
    flrw_out_t       single_res;
    logic            burst_start;
    logic [19:0]     sil_inc;
    logic [5:0]      fill_inc;
    logic [5:0]      need;

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        fill_next    = fill_reg;
        silence_next = silence_reg;
        stop_next    = stop_reg;
        single_load  = 1'b0;
        single_res   = '0;
        burst_start  = 1'b0;
        wr_en        = 1'b0;
        sil_inc      = (silence_reg != SILENCE_MAX) ? silence_reg + 20'd1 : silence_reg;
        fill_inc     = fill_reg + 6'd1;
        need         = kind_reg ? 6'd1 : P6;
        if (cmd.accept)
        begin
            if (in_data.op == OP_TICK)
            begin
                silence_next = sil_inc;
                if ((sil_inc > cfg.timeout_ticks) && !stop_reg)
                begin
                    stop_next            = 1'b1;
                    single_load          = 1'b1;
                    single_res.event_res = EV_STOP;
                    single_res.last      = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        if (!kind_reg)
                        begin
                            if (in_data.rx_byte == 8'(PAYLOAD_BYTES))
                            begin
                                fill_next  = 6'd0;
                                phase_next = PH_BODY;
                            end
                            else
                            begin
                                single_load            = 1'b1;
                                single_res.event_res   = EV_NACK;
                                single_res.last        = 1'b1;
                                single_res.reply_valid = 1'b1;
                                single_res.reply_byte  = cfg.nack_reply;
                                phase_next             = PH_START;
                            end
                        end
                        else if (in_data.rx_byte == 8'd1)
                        begin
                            fill_next  = 6'd0;
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            phase_next = PH_START;
                        end
                    end
                    PH_BODY:
                    begin
                        wr_en     = (fill_reg < P6);
                        fill_next = fill_inc;
                        if (fill_inc >= need)
                        begin
                            if (!kind_reg)
                            begin
                                burst_start  = 1'b1;
                                silence_next = 20'd0;
                                stop_next    = 1'b0;
                            end
                            else
                            begin
                                single_load             = 1'b1;
                                single_res.event_res    = EV_RESET;
                                single_res.payload_byte = in_data.rx_byte;
                                single_res.last         = 1'b1;
                            end
                            phase_next = PH_START;
                        end
                    end
                    default:
                    begin
                        if (in_data.rx_byte == cfg.start_byte)
                        begin
                            kind_next  = 1'b0;
                            phase_next = PH_LEN;
                        end
                        else if (in_data.rx_byte == cfg.reset_frame_byte)
                        begin
                            kind_next  = 1'b1;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            phase_next = PH_START;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (burst_start)
        begin
            cnt_next = '0;
        end
        else if (cmd.burst_inc)
        begin
            cnt_next = cnt_reg + AW'(1);
        end
    end

    assign sts.burst_start = burst_start;
    assign sts.burst_last  = (cnt_reg == LAST_IDX);
    assign sts.slot_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (single_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = single_res;
        end
        else if (cmd.burst_load)
        begin
            out_valid_next             = 1'b1;
            out_data_next.event_res    = EV_PAYLOAD;
            out_data_next.payload_byte = rd_data_reg;
            out_data_next.byte_index   = 6'(cnt_reg);
            out_data_next.last         = sts.burst_last;
            out_data_next.reply_valid  = sts.burst_last;
            out_data_next.reply_byte   = sts.burst_last ? cfg.ack_reply : 8'd0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= in_data.rx_byte;
        end
        rd_data_reg  <= mem[cnt_reg];
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            kind_reg      <= 1'b0;
            fill_reg      <= 6'd0;
            silence_reg   <= 20'd0;
            stop_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            fill_reg      <= fill_next;
            silence_reg   <= silence_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/flrw_ctrl.sv @@
// Controller: input acceptance and sequencing of the payload burst.
module flrw_ctrl
    import flrw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready;

    assign in_ready = (state_reg == ST_IDLE) && sts.slot_free;
    assign in_stall = !in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.burst_load = 1'b0;
        cmd.burst_inc  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid && in_ready;
                if (cmd.accept && sts.burst_start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.slot_free)
                begin
                    cmd.burst_load = 1'b1;
                    if (sts.burst_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.burst_inc = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/framed_link_receiver_with_watchdog.sv @@
// Top level of the framed link receiver: register file, controller and datapath.
//
// The input channel carries one beat per received link byte or elapsed tick
// (in_valid, in_stall, in_data). The output channel carries one beat per
// result (out_valid, out_stall, out_data). Registers must be written over the
// APB port only while the block is idle; the block itself does not enforce it.
// A stop, nack or reset result appears in the output register in the cycle
// after the byte or tick that causes it is taken. A byte that completes a
// normal frame starts a burst of PAYLOAD_BYTES results, each read through
// the registered read port of the frame store (ST_READ, then ST_LOAD); no new
// input beat is taken until the burst has ended.
// Reset restores the register defaults, puts the parser back to hunting for
// an opening byte and clears the silence count and the stop flag. The frame
// store is not cleared. While the receiver stalls, the result waiting in the
// output register holds, and no new input beat is taken.
module framed_link_receiver_with_watchdog
    import flrw_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  flrw_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output flrw_out_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg_reg, cfg_next;
    cmd_t       cmd;
    sts_t       sts;
    logic       wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr      = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (reg_idx)
                REG_START_BYTE: cfg_next.start_byte       = pwdata[7:0];
                REG_RESET_BYTE: cfg_next.reset_frame_byte = pwdata[7:0];
                REG_ACK_REPLY:  cfg_next.ack_reply        = pwdata[7:0];
                REG_NACK_REPLY: cfg_next.nack_reply       = pwdata[7:0];
                REG_TIMEOUT:    cfg_next.timeout_ticks    = pwdata[19:0];
                default:        cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_BYTE: prdata = 32'(cfg_reg.start_byte);
            REG_RESET_BYTE: prdata = 32'(cfg_reg.reset_frame_byte);
            REG_ACK_REPLY:  prdata = 32'(cfg_reg.ack_reply);
            REG_NACK_REPLY: prdata = 32'(cfg_reg.nack_reply);
            REG_TIMEOUT:    prdata = 32'(cfg_reg.timeout_ticks);
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte       <= START_BYTE_RST;
            cfg_reg.reset_frame_byte <= RESET_BYTE_RST;
            cfg_reg.ack_reply        <= ACK_REPLY_RST;
            cfg_reg.nack_reply       <= NACK_REPLY_RST;
            cfg_reg.timeout_ticks    <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    flrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    flrw_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ hw/rtl/flrw_chk.sv @@
// Port checker for the framed link receiver, bound to the top level.
`include "framed_link_receiver_with_watchdog_defines.svh"

module flrw_chk
    import flrw_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input flrw_out_t out_data
);

    `FLRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output beat changed")
    `FLRW_ASSERT_NOW(a_no_take_on_full, out_valid && out_stall, in_stall, "input taken while output is blocked")
    `FLRW_ASSERT_NOW(a_stop_shape, out_valid && (out_data.event_res == EV_STOP), out_data.last && !out_data.reply_valid, "stop beat malformed")
    `FLRW_ASSERT_NOW(a_reply_last, out_valid && out_data.reply_valid, out_data.last, "reply on a beat that is not last")

endmodule

bind framed_link_receiver_with_watchdog flrw_chk u_chk (.*);

@@ tb/framed_link_receiver_with_watchdog_test.sv @@
// Self-checking testbench for the framed link receiver with its silence watchdog.
`timescale 1ns / 100ps

module framed_link_receiver_with_watchdog_test;
    import flrw_pkg::*;

    localparam int FRAME_LEN = PAYLOAD_BYTES_DEF;
    localparam int SETTLE_CYCLES = 2 * FRAME_LEN + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    class link_frame_scoreboard;
        logic [7:0] start_code;
        logic [7:0] reset_code;
        logic [7:0] ack_code;
        logic [7:0] nack_code;
        logic [19:0] timeout;
        phase_t parse_state;
        logic reset_kind;
        logic [5:0] fill_count;
        logic [7:0] frame_bytes [FRAME_LEN];
        logic [19:0] silence;
        logic stop_raised;
        flrw_out_t results_due[$];
        int errors;

        function new();
            start_code = START_BYTE_RST;
            reset_code = RESET_BYTE_RST;
            ack_code = ACK_REPLY_RST;
            nack_code = NACK_REPLY_RST;
            timeout = TIMEOUT_RST;
            parse_state = PH_START;
            reset_kind = 1'b0;
            fill_count = '0;
            silence = '0;
            stop_raised = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_START_BYTE: start_code = value[7:0];
                REG_RESET_BYTE: reset_code = value[7:0];
                REG_ACK_REPLY: ack_code = value[7:0];
                REG_NACK_REPLY: nack_code = value[7:0];
                REG_TIMEOUT: timeout = value[19:0];
                default: ;
            endcase
        endfunction

        function void queue_result(logic [1:0] ev, logic [7:0] pay, logic [5:0] idx,
                                   logic fin, logic rv, logic [7:0] rb);
            flrw_out_t r;
            r.event_res = ev;
            r.payload_byte = pay;
            r.byte_index = idx;
            r.last = fin;
            r.reply_valid = rv;
            r.reply_byte = rb;
            results_due.push_back(r);
        endfunction

        function void take_beat(flrw_in_t beat);
            int need;
            logic fin;
            if (beat.op == OP_TICK) begin
                if (silence != SILENCE_MAX)
                    silence = silence + 20'd1;
                if (silence > timeout && !stop_raised) begin
                    stop_raised = 1'b1;
                    queue_result(EV_STOP, 8'd0, 6'd0, 1'b1, 1'b0, 8'd0);
                end
            end else begin
                case (parse_state)
                    PH_LEN: begin
                        if (!reset_kind) begin
                            if (beat.rx_byte == FRAME_LEN) begin
                                fill_count = '0;
                                parse_state = PH_BODY;
                            end else begin
                                queue_result(EV_NACK, 8'd0, 6'd0, 1'b1, 1'b1, nack_code);
                                parse_state = PH_START;
                            end
                        end else if (beat.rx_byte == 8'd1) begin
                            fill_count = '0;
                            parse_state = PH_BODY;
                        end else begin
                            parse_state = PH_START;
                        end
                    end
                    PH_BODY: begin
                        need = reset_kind ? 1 : FRAME_LEN;
                        if (fill_count < FRAME_LEN)
                            frame_bytes[fill_count] = beat.rx_byte;
                        fill_count = fill_count + 6'd1;
                        if (int'(fill_count) >= need) begin
                            if (!reset_kind) begin
                                for (int i = 0; i < FRAME_LEN; i++) begin
                                    fin = (i == FRAME_LEN - 1);
                                    queue_result(EV_PAYLOAD, frame_bytes[i], 6'(i), fin, fin,
                                                 fin ? ack_code : 8'd0);
                                end
                                silence = '0;
                                stop_raised = 1'b0;
                            end else begin
                                queue_result(EV_RESET, frame_bytes[0], 6'd0, 1'b1, 1'b0, 8'd0);
                            end
                            parse_state = PH_START;
                        end
                    end
                    default: begin
                        if (beat.rx_byte == start_code) begin
                            reset_kind = 1'b0;
                            parse_state = PH_LEN;
                        end else if (beat.rx_byte == reset_code) begin
                            reset_kind = 1'b1;
                            parse_state = PH_LEN;
                        end else begin
                            parse_state = PH_START;
                        end
                    end
                endcase
            end
        endfunction

        function void check_result(flrw_out_t got);
            flrw_out_t want;
            if (results_due.size() == 0) begin
                $error("unexpected result %h with nothing pending", got);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (got.event_res !== want.event_res) begin
                    $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
                    errors++;
                end
                if (got.payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0d, actual %0d",
                           want.payload_byte, got.payload_byte);
                    errors++;
                end
                if (got.byte_index !== want.byte_index) begin
                    $error("byte_index: expected %0d, actual %0d",
                           want.byte_index, got.byte_index);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    errors++;
                end
                if (got.reply_valid !== want.reply_valid) begin
                    $error("reply_valid: expected %0d, actual %0d",
                           want.reply_valid, got.reply_valid);
                    errors++;
                end
                if (got.reply_byte !== want.reply_byte) begin
                    $error("reply_byte: expected %0d, actual %0d",
                           want.reply_byte, got.reply_byte);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    flrw_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    flrw_out_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bit calm = 1'b0;
    bit hold_output = 1'b0;
    int quiet_cycles = 0;
    link_frame_scoreboard sb;

    framed_link_receiver_with_watchdog u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("framed_link_receiver_with_watchdog_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_output) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] value);
        flrw_in_t beat;
        int gap;
        beat.op = op;
        beat.rx_byte = value;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_beat(beat);
    endtask

    task automatic drain_results(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.results_due.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [7:0] start_code, input logic [7:0] reset_code,
                             input logic [7:0] ack_code, input logic [7:0] nack_code,
                             input logic [19:0] timeout);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_START_BYTE, {24'd0, start_code});
        write_reg(REG_RESET_BYTE, {24'd0, reset_code});
        write_reg(REG_ACK_REPLY, {24'd0, ack_code});
        write_reg(REG_NACK_REPLY, {24'd0, nack_code});
        write_reg(REG_TIMEOUT, {12'd0, timeout});
    endtask

    task automatic send_frame();
        send_beat(OP_BYTE, sb.start_code);
        send_beat(OP_BYTE, 8'(FRAME_LEN));
        repeat (FRAME_LEN) send_beat(OP_BYTE, 8'($urandom));
    endtask

    task automatic random_traffic(input int budget);
        int sent;
        int pick;
        logic [7:0] len;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            len = 8'($urandom);
            if (pick < 30) begin
                send_frame();
                sent += FRAME_LEN + 2;
            end else if (pick < 45) begin
                send_beat(OP_BYTE, sb.reset_code);
                send_beat(OP_BYTE, 8'd1);
                send_beat(OP_BYTE, len);
                sent += 3;
            end else if (pick < 52) begin
                if (len == 8'd1)
                    len = 8'd0;
                send_beat(OP_BYTE, sb.reset_code);
                send_beat(OP_BYTE, len);
                sent += 2;
            end else if (pick < 62) begin
                if (len == FRAME_LEN)
                    len = 8'hFF;
                send_beat(OP_BYTE, sb.start_code);
                send_beat(OP_BYTE, len);
                sent += 2;
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 8)) begin
                    send_beat(OP_TICK, 8'($urandom));
                    sent++;
                end
            end else begin
                send_beat(OP_BYTE, len);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Garbage while hunting, wrong lengths of both frame kinds, good reset frames.
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, sb.start_code);
        send_beat(OP_BYTE, 8'(FRAME_LEN - 1));
        send_beat(OP_BYTE, sb.start_code);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, sb.start_code);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, sb.reset_code);
        send_beat(OP_BYTE, 8'd1);
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_BYTE, sb.reset_code);
        send_beat(OP_BYTE, 8'd1);
        send_beat(OP_BYTE, 8'h5A);
        send_beat(OP_BYTE, sb.reset_code);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, sb.reset_code);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_TICK, 8'hFF);
        send_beat(OP_TICK, 8'h00);
        random_traffic(25);

        // Both opening bytes equal and a zero timeout.
        write_all(8'h7E, 8'h7E, 8'hFF, 8'h00, 20'd0);
        send_beat(OP_TICK, 8'h00);
        send_beat(OP_TICK, 8'hFF);
        send_beat(OP_BYTE, 8'h7E);
        send_beat(OP_BYTE, 8'd1);
        random_traffic(35);

        // The receiver holds off while a frame piles up behind it.
        write_all(8'h00, 8'hFF, 8'h00, 8'hFF, SILENCE_MAX);
        hold_output = 1'b1;
        send_frame();
        random_traffic(15);
        drain_results(0);
        random_traffic(25);

        write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  20'($urandom_range(1, 6)));
        calm = 1'b1;
        random_traffic(40);

        drain_results(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("framed_link_receiver_with_watchdog_test: PASS");
        else
            $display("framed_link_receiver_with_watchdog_test: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/flrw_pkg.sv
hw/rtl/flrw_dp.sv
hw/rtl/flrw_ctrl.sv
hw/rtl/framed_link_receiver_with_watchdog.sv
hw/rtl/flrw_chk.sv
tb/framed_link_receiver_with_watchdog_test.sv
